FILE: design/b2da_pkg.sv
// shared constants, types and power-of-ten helper for the binary to decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

   // number of value bits that take part in the conversion
   localparam int VALUE_WIDTH = 64;
   // width of the value field on the request beat
   localparam int IN_WIDTH = 64;
   localparam int DIGIT_COUNT = 20;
   localparam int COUNT_WIDTH = 5;
   localparam int CHAR_WIDTH = 6;
   localparam int RSP_DATA_WIDTH = 16;
   // wide enough for nine times the top power of ten
   localparam int PRODUCT_WIDTH = 68;

   localparam logic [IN_WIDTH-1:0] VALUE_MASK = (VALUE_WIDTH >= IN_WIDTH) ?
      {IN_WIDTH{1'b1}} : IN_WIDTH'(((IN_WIDTH+1)'(1) << VALUE_WIDTH) - (IN_WIDTH+1)'(1));

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = 6'd57;

   typedef logic [3:0] digit_type;

   // converted value: digit 0 is the most significant (ten to the 19th)
   typedef struct packed {
      digit_type [DIGIT_COUNT-1:0] digits;
      logic [COUNT_WIDTH-1:0]      count;
   } conv_type;

   // multiple times ten to the given exponent, evaluated at elaboration only
   function automatic logic [PRODUCT_WIDTH-1:0] pow10_times(input int unsigned exponent,
                                                            input int unsigned multiple);
      logic [PRODUCT_WIDTH-1:0] acc;
      acc = PRODUCT_WIDTH'(multiple);
      for (int unsigned i = 0; i < exponent; i++) begin
         acc = acc * PRODUCT_WIDTH'(10);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

FILE: design/b2da_digit_pipe.sv
// digit extraction pipeline, one decimal digit per register stage
`timescale 1ns / 1ps
`default_nettype none

module b2da_digit_pipe (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [b2da_pkg::IN_WIDTH-1:0]  in_value,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output b2da_pkg::conv_type                  out_conv
);
   import b2da_pkg::*;

   logic [DIGIT_COUNT-1:0] vld_ff;
   logic [DIGIT_COUNT-1:0] vld_in;
   logic [DIGIT_COUNT-1:0] src_vld;
   logic [DIGIT_COUNT:0]   adv;
   logic [IN_WIDTH-1:0]    rem_ff  [DIGIT_COUNT];
   logic [IN_WIDTH-1:0]    rem_in  [DIGIT_COUNT];
   logic [IN_WIDTH-1:0]    src_rem [DIGIT_COUNT];
   conv_type               conv_ff  [DIGIT_COUNT];
   conv_type               conv_in  [DIGIT_COUNT];
   conv_type               src_conv [DIGIT_COUNT];

   assign adv[DIGIT_COUNT] = out_ready;
   assign in_ready         = adv[0];
   assign out_valid        = vld_ff[DIGIT_COUNT-1];
   assign out_conv         = conv_ff[DIGIT_COUNT-1];

   for (genvar s = 0; s < DIGIT_COUNT; s++) begin : g_stage
      localparam int unsigned EXP = DIGIT_COUNT - 1 - s;
      localparam logic [PRODUCT_WIDTH-1:0] MULT [9] = '{
         pow10_times(EXP, 1), pow10_times(EXP, 2), pow10_times(EXP, 3),
         pow10_times(EXP, 4), pow10_times(EXP, 5), pow10_times(EXP, 6),
         pow10_times(EXP, 7), pow10_times(EXP, 8), pow10_times(EXP, 9)};

      if (s == 0) begin : g_head
         assign src_vld[s]  = in_valid;
         assign src_rem[s]  = in_value & VALUE_MASK;
         assign src_conv[s] = '0;
      end else begin : g_body
         assign src_vld[s]  = vld_ff[s-1];
         assign src_rem[s]  = rem_ff[s-1];
         assign src_conv[s] = conv_ff[s-1];
      end

      // a stage moves when it is empty or the one after it moves
      assign adv[s] = !vld_ff[s] || adv[s+1];

      // all nine trial subtractions in parallel, keep the largest that fits
      always_comb begin : p_digit
         logic [PRODUCT_WIDTH-1:0] wide;
         logic [PRODUCT_WIDTH-1:0] diff;
         digit_type                q;
         logic [IN_WIDTH-1:0]      r;
         wide = PRODUCT_WIDTH'(src_rem[s]);
         q    = '0;
         r    = src_rem[s];
         for (int m = 0; m < 9; m++) begin
            diff = wide - MULT[m];
            if (!diff[PRODUCT_WIDTH-1]) begin
               q = 4'(m + 1);
               r = diff[IN_WIDTH-1:0];
            end
         end
         rem_in[s]            = r;
         conv_in[s]           = src_conv[s];
         conv_in[s].digits[s] = q;
         if (q != '0 || src_conv[s].count != '0) begin
            conv_in[s].count = src_conv[s].count + COUNT_WIDTH'(1);
         end
         vld_in[s] = adv[s] ? src_vld[s] : vld_ff[s];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
         if (adv[s] && src_vld[s]) begin
            rem_ff[s]  <= rem_in[s];
            conv_ff[s] <= conv_in[s];
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/b2da_serializer.sv
// holds one converted value and sends its significant digits one beat at a time
`timescale 1ns / 1ps
`default_nettype none

module b2da_serializer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire b2da_pkg::conv_type                in_conv,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]        out_char,
   output logic                                   out_last,
   output logic [b2da_pkg::COUNT_WIDTH-1:0]       out_count
);
   import b2da_pkg::*;

   logic                             buf_vld_ff, buf_vld_in;
   digit_type [DIGIT_COUNT-1:0]      digits_ff, digits_in;
   logic [COUNT_WIDTH-1:0]           pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0]           cnt_ff, cnt_in;
   logic                             out_vld_ff, out_vld_in;
   logic [CHAR_WIDTH-1:0]            char_ff, char_in;
   logic                             last_ff, last_in;
   logic [COUNT_WIDTH-1:0]           ocnt_ff, ocnt_in;

   logic                             move;
   logic                             at_end;
   logic                             load;
   logic [COUNT_WIDTH-1:0]           load_cnt;

   assign move     = buf_vld_ff && (!out_vld_ff || out_ready);
   assign at_end   = pos_ff == COUNT_WIDTH'(DIGIT_COUNT - 1);
   assign in_ready = !buf_vld_ff || (move && at_end);
   assign load     = in_valid && in_ready;
   // a zero value still gives one digit
   assign load_cnt = (in_conv.count == '0) ? COUNT_WIDTH'(1) : in_conv.count;

   always_comb begin
      buf_vld_in = buf_vld_ff;
      digits_in  = digits_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      if (load) begin
         buf_vld_in = 1'b1;
         digits_in  = in_conv.digits;
         pos_in     = COUNT_WIDTH'(DIGIT_COUNT) - load_cnt;
         cnt_in     = load_cnt;
      end else if (move) begin
         buf_vld_in = !at_end;
         pos_in     = pos_ff + COUNT_WIDTH'(1);
      end

      out_vld_in = out_vld_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      ocnt_in    = ocnt_ff;
      if (move) begin
         out_vld_in = 1'b1;
         char_in    = ASCII_ZERO + {2'b00, digits_ff[pos_ff]};
         last_in    = at_end;
         ocnt_in    = at_end ? cnt_ff : '0;
      end else if (out_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         pos_ff     <= '0;
      end else begin
         buf_vld_ff <= buf_vld_in;
         out_vld_ff <= out_vld_in;
         pos_ff     <= pos_in;
      end
      digits_ff <= digits_in;
      cnt_ff    <= cnt_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      ocnt_ff   <= ocnt_in;
   end

   assign out_valid = out_vld_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_count = ocnt_ff;

`ifndef NO_ASSERTIONS
   a_last_count : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && last_ff |-> ocnt_ff != '0 && ocnt_ff <= COUNT_WIDTH'(DIGIT_COUNT))
      else $error("count on last beat out of range");

   a_mid_count : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !last_ff |-> ocnt_ff == '0)
      else $error("count nonzero on a middle beat");

   a_char_range : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> char_ff >= ASCII_ZERO && char_ff <= ASCII_NINE)
      else $error("character is not a decimal digit");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      buf_vld_ff |-> pos_ff <= COUNT_WIDTH'(DIGIT_COUNT - 1))
      else $error("digit position past the end");

   a_run_holds : assert property (@(posedge clock) disable iff (reset)
      move && !at_end |=> buf_vld_ff && pos_ff == $past(pos_ff) + COUNT_WIDTH'(1))
      else $error("run dropped before its last digit");
`endif

endmodule

`default_nettype wire

FILE: design/binary_to_decimal_ascii.sv
// top level of the 64-bit binary to decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none

// Converts one unsigned binary value per request beat into its decimal text,
// sent as one ascii digit per response beat, most significant digit first and
// without leading zeros (zero gives a single '0'). The last beat of each run
// has tlast set and carries the digit count; other beats carry a count of 0.
// Values enter a twenty-stage digit pipeline (one power of ten per stage, a
// parallel trial subtraction of the nine multiples), so a new value can be
// taken every cycle while the pipe has room. The response channel is the
// limit: a value of n digits, 1 to 20, occupies it for n response beats, one
// digit per beat. A request passes the 20 pipeline stages, the digit buffer
// and the output register before its first response beat. Reset is synchronous
// and clears only valid and position state.
module binary_to_decimal_ascii (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request: one value per beat
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [b2da_pkg::IN_WIDTH-1:0]        req_tdata,   // [63:0] value
   // response: one digit character per beat
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [b2da_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,   // [5:0] digit_char,
                                                                  // [10:6] digit_count,
                                                                  // [15:11] zero
   output logic                                      rsp_tlast    // last_digit
);
   import b2da_pkg::*;

   // pipe to serializer handoff
   logic                   conv_valid;
   logic                   conv_ready;
   conv_type               conv;

   logic [CHAR_WIDTH-1:0]  digit_char;
   logic [COUNT_WIDTH-1:0] digit_count;

   // digit extraction, one power of ten per stage
   b2da_digit_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata),
      .out_valid (conv_valid),
      .out_ready (conv_ready),
      .out_conv  (conv)
   );

   // buffer plus output register, so the next value loads while a digit waits
   b2da_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (conv_ready),
      .in_conv   (conv),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (digit_char),
      .out_last  (rsp_tlast),
      .out_count (digit_count)
   );

   // pack response fields from the low bit up, zero fill to whole bytes
   assign rsp_tdata = {(RSP_DATA_WIDTH - COUNT_WIDTH - CHAR_WIDTH)'(0), digit_count, digit_char};

endmodule

`default_nettype wire
